@@ rtl/puv_pkg.sv @@
// Package for the path UTF-8 validator: shared constants and types.
// No dependencies; imported by puv_utf8 and path_utf8_validator.
`default_nettype none

package puv_pkg;

  localparam int unsigned MaxPathLenDef = 4096;
  localparam int unsigned CfgW = 13;

  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CtrlLimit = 8'h20;

  typedef enum logic [3:0] {
    SEG_SLASH = 4'b0001,
    SEG_DOT1  = 4'b0010,
    SEG_DOT2  = 4'b0100,
    SEG_OTHER = 4'b1000
  } seg_phase_e;

  typedef struct packed {
    logic [1:0]  cont_left;
    logic [1:0]  seq_class;
    logic [20:0] cp;
  } utf8_state_t;

endpackage

`default_nettype wire

@@ rtl/puv_utf8.sv @@
// Strict UTF-8 decoder step: next decoder state and error flag for one byte.
// Depends on puv_pkg for the decoder state type.
`default_nettype none

module puv_utf8 import puv_pkg::*; (
  input  utf8_state_t state_i,
  input  logic [7:0]  byte_i,
  output utf8_state_t state_o,
  output logic        err_o
);

  localparam logic [20:0] SurLo = 21'h00D800;
  localparam logic [20:0] SurHi = 21'h00DFFF;
  localparam logic [20:0] CpMax = 21'h10FFFF;
  localparam logic [20:0] Min3  = 21'h000800;
  localparam logic [20:0] Min4  = 21'h010000;

  logic [20:0] cp_shift;

  assign cp_shift = {state_i.cp[14:0], byte_i[5:0]};

  always_comb begin
    state_o = state_i;
    err_o   = 1'b0;
    if (state_i.cont_left != 2'd0) begin
      if (byte_i[7:6] != 2'b10) begin
        err_o             = 1'b1;
        state_o.cont_left = 2'd0;
      end else begin
        state_o.cp        = cp_shift;
        state_o.cont_left = state_i.cont_left - 2'd1;
        if (state_i.cont_left == 2'd1) begin
          if ((cp_shift >= SurLo && cp_shift <= SurHi) || cp_shift > CpMax ||
              (cp_shift < Min3 && state_i.seq_class >= 2'd2) ||
              (cp_shift < Min4 && state_i.seq_class == 2'd3)) begin
            err_o = 1'b1;
          end
        end
      end
    end else if (byte_i[7]) begin
      if (byte_i inside {[8'hC2:8'hDF]}) begin
        state_o.cp        = {16'd0, byte_i[4:0]};
        state_o.seq_class = 2'd1;
        state_o.cont_left = 2'd1;
      end else if (byte_i inside {[8'hE0:8'hEF]}) begin
        state_o.cp        = {17'd0, byte_i[3:0]};
        state_o.seq_class = 2'd2;
        state_o.cont_left = 2'd2;
      end else if (byte_i inside {[8'hF0:8'hF4]}) begin
        state_o.cp        = {18'd0, byte_i[2:0]};
        state_o.seq_class = 2'd3;
        state_o.cont_left = 2'd3;
      end else begin
        err_o = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/path_utf8_validator.sv @@
// Top level of the path UTF-8 validator: input register, rule checks and result register.
// Depends on puv_pkg and puv_utf8.
`default_nettype none

// Checks an absolute path streamed one byte per transfer, with is_last_i on the final
// byte, and gives one verdict transfer (path_ok_o) per path. A path passes when it starts
// with '/', does not end with '/', has no "//", no byte below 0x20, no ".." segment, is
// no longer than the configured limit and is strict UTF-8. The block takes one byte every
// cycle. The edge that takes a byte loads the input register, and the checks run from
// there into the result register that holds the verdict. Input stalls only when a last
// byte waits for a result register that is still full. The limit register (cfg_wdata_i,
// 0 acts as 1, values above MAX_PATH_LEN act as MAX_PATH_LEN) resets to MAX_PATH_LEN;
// the user must write it only between paths; the block does not enforce this.
module path_utf8_validator import puv_pkg::*; #(
  parameter int unsigned MAX_PATH_LEN = MaxPathLenDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      path_byte_i,
  input  logic            is_last_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            path_ok_o,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i
);

  localparam int unsigned CntW = $clog2(MAX_PATH_LEN + 2);
  localparam int unsigned CmpW = (CntW > CfgW) ? CntW : CfgW;

  logic [CntW-1:0] lim_q;
  logic [CmpW-1:0] cfg_ext;
  logic [CmpW-1:0] cfg_clamped;

  logic            s1_valid_q;
  logic [7:0]      s1_byte_q;
  logic            s1_last_q;
  logic            s1_adv;
  logic            in_accept;

  logic [CntW-1:0] cnt_q, cnt_d, cnt_inc;
  seg_phase_e      seg_q, seg_d;
  utf8_state_t     utf8_q, utf8_next, utf8_d;
  logic            utf8_err;
  logic            err_q, err_next, err_d;
  logic            first;
  logic            verdict;

  logic            out_valid_q;
  logic            path_ok_q;

  assign cfg_ext = CmpW'(cfg_wdata_i);

  always_comb begin
    cfg_clamped = cfg_ext;
    if (cfg_ext == '0) begin
      cfg_clamped = CmpW'(1);
    end else if (cfg_ext > CmpW'(MAX_PATH_LEN)) begin
      cfg_clamped = CmpW'(MAX_PATH_LEN);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= CntW'(MAX_PATH_LEN);
    end else if (cfg_we_i) begin
      lim_q <= CntW'(cfg_clamped);
    end
  end

  assign s1_adv     = s1_valid_q && (!s1_last_q || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= path_byte_i;
      s1_last_q <= is_last_i;
    end
  end

  puv_utf8 u_utf8 (
    .state_i (utf8_q),
    .byte_i  (s1_byte_q),
    .state_o (utf8_next),
    .err_o   (utf8_err)
  );

  always_comb begin
    first    = (cnt_q == '0);
    err_next = err_q || utf8_err;
    cnt_inc  = (cnt_q <= lim_q) ? cnt_q + CntW'(1) : cnt_q;
    cnt_d    = cnt_inc;
    if (cnt_inc > lim_q) begin
      err_next = 1'b1;
      cnt_d    = lim_q + CntW'(1);
    end
    if (first && s1_byte_q != CharSlash) begin
      err_next = 1'b1;
    end
    if (s1_byte_q < CtrlLimit) begin
      err_next = 1'b1;
    end
    if (s1_byte_q == CharSlash) begin
      if ((!first && seg_q == SEG_SLASH) || seg_q == SEG_DOT2) begin
        err_next = 1'b1;
      end
      seg_d = SEG_SLASH;
    end else if (s1_byte_q == CharDot) begin
      case (seg_q)
        SEG_SLASH: seg_d = SEG_DOT1;
        SEG_DOT1:  seg_d = SEG_DOT2;
        default:   seg_d = SEG_OTHER;
      endcase
    end else begin
      seg_d = SEG_OTHER;
    end
    utf8_d  = utf8_next;
    err_d   = err_next;
    verdict = !(err_next || s1_byte_q == CharSlash || seg_d == SEG_DOT2 ||
                utf8_next.cont_left != 2'd0);
    if (s1_last_q) begin
      cnt_d  = '0;
      seg_d  = SEG_SLASH;
      utf8_d = '0;
      err_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      seg_q  <= SEG_SLASH;
      utf8_q <= '0;
      err_q  <= 1'b0;
    end else if (s1_adv) begin
      cnt_q  <= cnt_d;
      seg_q  <= seg_d;
      utf8_q <= utf8_d;
      err_q  <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      path_ok_q <= verdict;
    end
  end

  assign out_valid_o = out_valid_q;
  assign path_ok_o   = path_ok_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_PATH_LEN + 1))
    else $error("byte count exceeds the saturation bound");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_last_q |=> cnt_q == '0 && seg_q == SEG_SLASH &&
                           utf8_q.cont_left == 2'd0 && !err_q)
    else $error("path state not cleared after the last byte");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_last_q |=> out_valid_o)
    else $error("verdict missing after the last byte");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && s1_last_q && out_valid_q && out_stall_i)
    else $error("input stalled without a blocked verdict");

endmodule

`default_nettype wire
